// ----- sv/gcm_pkg.sv -----
`default_nettype none

package gcm_pkg;

  // Word geometry of the coefficient stream.
  localparam int WORD_W = 64;
  // h coefficients consumed per lane step.
  localparam int STEP_BITS = 4;
  localparam int STEPS_PER_WORD = WORD_W / STEP_BITS;
  localparam int STEP_CNT_W = $clog2(STEPS_PER_WORD);

  // Configuration register.
  localparam int LOG_W = 3;
  localparam logic [LOG_W-1:0] LOG_RESET = 3'd4;

  // Basis polynomials held in every lane.
  localparam int BASIS_N = 4;
  localparam int P_F  = 0;
  localparam int P_G  = 1;
  localparam int P_BF = 2;
  localparam int P_BG = 3;

  typedef logic [BASIS_N-1:0][WORD_W-1:0] basis_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_EMIT
  } state_t;

  // Per-lane control, one bundle per lane.
  typedef struct packed {
    logic                 wr;
    logic                 step;
    logic                 clear;
    logic [STEP_BITS-1:0] h0;
    logic [STEP_BITS-1:0] h1;
  } lane_ctl_t;

  // Word of (cur:prev) * X^d, taking the carried bits from the lower neighbour.
  function automatic logic [WORD_W-1:0] join_shift(
    input logic [WORD_W-1:0] cur,
    input logic [WORD_W-1:0] prev,
    input int unsigned       d
  );
    logic [2*WORD_W-1:0] t;
    t = {cur, prev} << d;
    return t[2*WORD_W-1:WORD_W];
  endfunction

endpackage

`default_nettype wire

// ----- sv/gcm_if.sv -----
`default_nettype none

// Input request channel.
interface gcm_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [63:0] f_bits;
  logic [63:0] g_bits;
  logic [63:0] bigf_bits;
  logic [63:0] bigg_bits;
  logic [63:0] h0_bits;
  logic [63:0] h1_bits;

  modport source (
    output valid, func, f_bits, g_bits, bigf_bits, bigg_bits, h0_bits, h1_bits,
    input  ready
  );
  modport sink (
    input  valid, func, f_bits, g_bits, bigf_bits, bigg_bits, h0_bits, h1_bits,
    output ready
  );
endinterface

// Result request channel.
interface gcm_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] t0_word;
  logic [63:0] t1_word;
  logic        last_word;

  modport source (output valid, t0_word, t1_word, last_word, input ready);
  modport sink (input valid, t0_word, t1_word, last_word, output ready);
endinterface

// Configuration write channel.
interface gcm_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] log_words;

  modport source (output valid, log_words, input ready);
  modport sink (input valid, log_words, output ready);
endinterface

`default_nettype wire

// ----- sv/gcm_lane.sv -----
`default_nettype none

// One word lane: holds basis word k of f, g, F and G, rotates it by
// STEP_BITS coefficients per step and accumulates word k of t0 and t1.
module gcm_lane (
  input  wire logic                          clk,
  input  wire gcm_pkg::lane_ctl_t            ctl,
  input  wire gcm_pkg::basis_t               wdata,
  input  wire gcm_pkg::basis_t               prev,
  output gcm_pkg::basis_t                    cur,
  output logic [gcm_pkg::WORD_W-1:0]         acc0,
  output logic [gcm_pkg::WORD_W-1:0]         acc1
);

  gcm_pkg::basis_t                basis;
  gcm_pkg::basis_t                basis_next;
  logic [gcm_pkg::WORD_W-1:0]     acc0_next;
  logic [gcm_pkg::WORD_W-1:0]     acc1_next;

  assign cur = basis;

  // Partial products for the STEP_BITS h coefficients of this step, and the
  // rotated basis for the next one.
  always_comb begin
    acc0_next = acc0;
    acc1_next = acc1;
    for (int d = 0; d < gcm_pkg::STEP_BITS; d++) begin
      if (ctl.h0[d]) begin
        acc0_next ^= gcm_pkg::join_shift(basis[gcm_pkg::P_F], prev[gcm_pkg::P_F], d);
        acc1_next ^= gcm_pkg::join_shift(basis[gcm_pkg::P_G], prev[gcm_pkg::P_G], d);
      end
      if (ctl.h1[d]) begin
        acc0_next ^= gcm_pkg::join_shift(basis[gcm_pkg::P_BF], prev[gcm_pkg::P_BF], d);
        acc1_next ^= gcm_pkg::join_shift(basis[gcm_pkg::P_BG], prev[gcm_pkg::P_BG], d);
      end
    end
    for (int p = 0; p < gcm_pkg::BASIS_N; p++) begin
      basis_next[p] = gcm_pkg::join_shift(basis[p], prev[p], gcm_pkg::STEP_BITS);
    end
  end

  // Basis words: loaded from the input, rotated in place during a product.
  // A full product rotates by the whole period, so they come back unchanged.
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      basis <= wdata;
    end else if (ctl.step) begin
      basis <= basis_next;
    end
  end

  // Product word accumulators.
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc0 <= '0;
      acc1 <= '0;
    end else if (ctl.step) begin
      acc0 <= acc0_next;
      acc1 <= acc1_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/gcm_merge.sv -----
`default_nettype none

// Result stage: picks one lane's product words and holds them in the
// output register until the request is taken.
module gcm_merge #(
  parameter int NLANES = 16,
  parameter int IDX_W  = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        load,
  input  wire logic [IDX_W-1:0]            sel,
  input  wire logic                        is_last,
  input  wire logic [gcm_pkg::WORD_W-1:0]  acc0 [NLANES],
  input  wire logic [gcm_pkg::WORD_W-1:0]  acc1 [NLANES],
  output logic                             can_load,
  gcm_out_if.source                        dout
);

  logic                        valid;
  logic [gcm_pkg::WORD_W-1:0]  t0;
  logic [gcm_pkg::WORD_W-1:0]  t1;
  logic                        last;

  assign can_load       = !valid || dout.ready;
  assign dout.valid     = valid;
  assign dout.t0_word   = t0;
  assign dout.t1_word   = t1;
  assign dout.last_word = last;

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (dout.ready) begin
      valid <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (load) begin
      t0   <= acc0[sel];
      t1   <= acc1[sel];
      last <= is_last;
    end
  end

endmodule

`default_nettype wire

// ----- sv/gf2_cyclic_matvec_2x2.sv -----
// A basis or non-final h request is stored when it is taken, and the block
// stays ready for the next one. The final h request starts a product (W =
// 2**log_words words, capped at the lane count, four h coefficients per cycle
// across W word lanes), then W results leave at one per cycle while the
// receiver keeps taking them. No new request is taken from the start of a
// product until its last result has been loaded into the output register.
// Reset: log_words returns to 4, word indexes to 0, no result pending; stored
// words are undefined until loaded.
`default_nettype none

module gf2_cyclic_matvec_2x2 #(
  parameter int MAX_WORDS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  gcm_in_if.sink     din,
  gcm_out_if.source  dout,
  gcm_cfg_if.sink    cfg
);

  localparam int LOG_MAX = $clog2(MAX_WORDS + 1) - 1;
  localparam int IDX_W   = (LOG_MAX > 0) ? LOG_MAX : 1;
  localparam int NLANES  = 1 << LOG_MAX;
  localparam int CNT_W   = IDX_W + gcm_pkg::STEP_CNT_W;
  localparam int SW      = gcm_pkg::STEP_CNT_W;

  gcm_pkg::state_t                state;
  gcm_pkg::state_t                state_next;
  logic [gcm_pkg::LOG_W-1:0]      log_words;
  logic [gcm_pkg::LOG_W-1:0]      lg_eff;
  logic [IDX_W-1:0]               m;
  logic [IDX_W-1:0]               basis_index;
  logic [IDX_W-1:0]               basis_index_next;
  logic [IDX_W-1:0]               h_index;
  logic [IDX_W-1:0]               h_index_next;
  logic [IDX_W-1:0]               b_wi;
  logic [IDX_W-1:0]               h_wi;
  logic [CNT_W-1:0]               step_cnt;
  logic [CNT_W-1:0]               step_cnt_next;
  logic [IDX_W-1:0]               emit_idx;
  logic [IDX_W-1:0]               emit_idx_next;
  logic [gcm_pkg::WORD_W-1:0]     h0_store [NLANES];
  logic [gcm_pkg::WORD_W-1:0]     h1_store [NLANES];
  logic [gcm_pkg::WORD_W-1:0]     h0_cur;
  logic [gcm_pkg::WORD_W-1:0]     h1_cur;
  logic [SW-1:0]                  nib;
  logic                           in_acc;
  logic                           basis_wr;
  logic                           h_wr;
  logic                           h_last;
  logic                           last_step;
  logic                           do_step;
  logic                           do_clear;
  logic                           out_load;
  logic                           can_load;
  logic                           emit_last;
  gcm_pkg::basis_t                wdata;
  gcm_pkg::basis_t                lane_cur [NLANES];
  gcm_pkg::lane_ctl_t             lane_ctl [NLANES];
  logic [gcm_pkg::WORD_W-1:0]     acc0 [NLANES];
  logic [gcm_pkg::WORD_W-1:0]     acc1 [NLANES];

  // Word count, saturated to what the lanes can hold.
  assign lg_eff = (log_words > gcm_pkg::LOG_W'(LOG_MAX)) ?
                  gcm_pkg::LOG_W'(LOG_MAX) : log_words;
  assign m      = IDX_W'((5'd1 << lg_eff) - 5'd1);

  // Input handshake and decode; nothing is taken while reset is held.
  assign din.ready = (state == gcm_pkg::ST_IDLE) && !rst;
  assign cfg.ready = !rst;
  assign in_acc    = din.valid && din.ready;
  assign basis_wr  = in_acc && !din.func;
  assign h_wr      = in_acc && din.func;
  assign b_wi      = basis_index & m;
  assign h_wi      = h_index & m;
  assign h_last    = (h_wi == m);

  assign wdata[gcm_pkg::P_F]  = din.f_bits;
  assign wdata[gcm_pkg::P_G]  = din.g_bits;
  assign wdata[gcm_pkg::P_BF] = din.bigf_bits;
  assign wdata[gcm_pkg::P_BG] = din.bigg_bits;

  // h coefficients for the current step.
  assign h0_cur    = h0_store[step_cnt[CNT_W-1:SW]];
  assign h1_cur    = h1_store[step_cnt[CNT_W-1:SW]];
  assign nib       = step_cnt[SW-1:0];
  assign last_step = (step_cnt == {m, {SW{1'b1}}});
  assign emit_last = (emit_idx == m);

  // Sequencer: load, compute, emit.
  always_comb begin
    state_next       = state;
    basis_index_next = basis_index;
    h_index_next     = h_index;
    step_cnt_next    = step_cnt;
    emit_idx_next    = emit_idx;
    do_step          = 1'b0;
    do_clear         = 1'b0;
    out_load         = 1'b0;
    unique case (state)
      gcm_pkg::ST_IDLE: begin
        if (basis_wr) begin
          basis_index_next = (b_wi + IDX_W'(1)) & m;
        end
        if (h_wr) begin
          if (h_last) begin
            h_index_next  = '0;
            do_clear      = 1'b1;
            step_cnt_next = '0;
            state_next    = gcm_pkg::ST_CALC;
          end else begin
            h_index_next = h_wi + IDX_W'(1);
          end
        end
      end
      gcm_pkg::ST_CALC: begin
        do_step = 1'b1;
        if (last_step) begin
          step_cnt_next = '0;
          emit_idx_next = '0;
          state_next    = gcm_pkg::ST_EMIT;
        end else begin
          step_cnt_next = step_cnt + CNT_W'(1);
        end
      end
      gcm_pkg::ST_EMIT: begin
        if (can_load) begin
          out_load = 1'b1;
          if (emit_last) begin
            emit_idx_next = '0;
            state_next    = gcm_pkg::ST_IDLE;
          end else begin
            emit_idx_next = emit_idx + IDX_W'(1);
          end
        end
      end
      default: begin
        state_next = gcm_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers; a configuration write restarts both word indexes.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= gcm_pkg::ST_IDLE;
      log_words   <= gcm_pkg::LOG_RESET;
      basis_index <= '0;
      h_index     <= '0;
      step_cnt    <= '0;
      emit_idx    <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
      emit_idx <= emit_idx_next;
      if (cfg.valid && cfg.ready) begin
        log_words   <= cfg.log_words;
        basis_index <= '0;
        h_index     <= '0;
      end else begin
        basis_index <= basis_index_next;
        h_index     <= h_index_next;
      end
    end
  end

  // h word store.
  always_ff @(posedge clk) begin
    if (h_wr) begin
      h0_store[h_wi] <= din.h0_bits;
      h1_store[h_wi] <= din.h1_bits;
    end
  end

  // Word lanes; lane 0 takes its carry from the top active lane.
  for (genvar k = 0; k < NLANES; k++) begin : g_lane
    gcm_pkg::basis_t prev;

    if (k == 0) begin : g_wrap
      assign prev = lane_cur[m];
    end else begin : g_chain
      assign prev = lane_cur[k-1];
    end

    always_comb begin
      lane_ctl[k].wr    = basis_wr && (b_wi == IDX_W'(k));
      lane_ctl[k].step  = do_step && (IDX_W'(k) <= m);
      lane_ctl[k].clear = do_clear;
      lane_ctl[k].h0    = h0_cur[nib*gcm_pkg::STEP_BITS +: gcm_pkg::STEP_BITS];
      lane_ctl[k].h1    = h1_cur[nib*gcm_pkg::STEP_BITS +: gcm_pkg::STEP_BITS];
    end

    gcm_lane u_lane (
      .clk   (clk),
      .ctl   (lane_ctl[k]),
      .wdata (wdata),
      .prev  (prev),
      .cur   (lane_cur[k]),
      .acc0  (acc0[k]),
      .acc1  (acc1[k])
    );
  end

  // Result stage.
  gcm_merge #(
    .NLANES (NLANES),
    .IDX_W  (IDX_W)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .load     (out_load),
    .sel      (emit_idx),
    .is_last  (emit_last),
    .acc0     (acc0),
    .acc1     (acc1),
    .can_load (can_load),
    .dout     (dout)
  );

  // The final h request always starts a product.
  a_last_h_starts: assert property (@(posedge clk) disable iff (rst)
    (h_wr && h_last && !(cfg.valid && cfg.ready)) |=> (state == gcm_pkg::ST_CALC))
    else $error("final h word did not start a product");

  // Counters are parked at zero while idle.
  a_idle_counters: assert property (@(posedge clk) disable iff (rst)
    (state == gcm_pkg::ST_IDLE) |-> ((step_cnt == '0) && (emit_idx == '0)))
    else $error("step or emit counter left running in idle");

  // The h index never points past the active word count.
  a_h_index_range: assert property (@(posedge clk) disable iff (rst)
    ((h_index & ~m) == '0))
    else $error("h index beyond word count");

endmodule

`default_nettype wire

// ----- tb/tb_gf2_cyclic_matvec_2x2.sv -----
`default_nettype none

module tb_gf2_cyclic_matvec_2x2;

  localparam int MAX_WORDS   = 16;
  localparam int LOG_LIMIT   = $clog2(MAX_WORDS);
  localparam int POLY_BITS   = MAX_WORDS * gcm_pkg::WORD_W;
  localparam int REG_LOG_WORDS = 0;
  localparam int SETTLE      = 4;
  localparam int TAIL        = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_ITEMS = 190;

  typedef logic [gcm_pkg::WORD_W-1:0] word_t;
  typedef logic [POLY_BITS-1:0] poly_t;
  typedef logic [MAX_WORDS-1:0][gcm_pkg::WORD_W-1:0] poly_words_t;
  typedef logic [gcm_pkg::LOG_W-1:0] setting_t;

  localparam word_t ONES    = '1;
  localparam word_t TOP_BIT = 64'h8000_0000_0000_0000;
  localparam poly_t ALL_SET = '1;

  typedef enum logic {
    OP_BASIS = 1'b0,
    OP_H     = 1'b1
  } op_e;

  typedef enum logic {
    ROW_CFG,
    ROW_REQ
  } row_e;

  typedef struct {
    row_e            kind;
    setting_t        setting;
    op_e             func;
    word_t           f;
    word_t           g;
    word_t           bf;
    word_t           bg;
    word_t           h0;
    word_t           h1;
    bit              typed;
    word_t           want_t0;
    word_t           want_t1;
  } row_t;

  typedef struct {
    word_t t0;
    word_t t1;
    logic  last;
  } result_t;

  logic clk = 1'b0;
  logic rst;

  gcm_in_if  in_ch ();
  gcm_out_if out_ch ();
  gcm_cfg_if cfg_ch ();

  gf2_cyclic_matvec_2x2 #(
    .MAX_WORDS(MAX_WORDS)
  ) dut (
    .clk  (clk),
    .rst  (rst),
    .din  (in_ch),
    .dout (out_ch),
    .cfg  (cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Own copy of the block state, kept in step with accepted requests.
  setting_t         log_setting;
  poly_words_t      f_word, g_word, bigf_word, bigg_word;
  poly_words_t      h0_word, h1_word;
  logic [MAX_WORDS-1:0] loaded;
  int               load_ptr;
  int               h_ptr;

  result_t pending_words[$];
  row_t    plan[$];

  int  errors;
  int  results_seen;
  int  items_sent;
  int  products;
  int  cfg_writes;
  bit  sender_calm;
  bit  hold_wanted;
  bit  hold_done;

  function automatic int words_now();
    setting_t lg;
    lg = (log_setting > LOG_LIMIT) ? setting_t'(LOG_LIMIT) : log_setting;
    return 1 << lg;
  endfunction

  function automatic bit basis_ready(input int nw);
    int i;
    for (i = 0; i < nw; i++) begin
      if (!loaded[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Multiply by X once, wrapping the top coefficient round to the bottom.
  function automatic poly_t turn_once(input poly_t p, input int n);
    return ((p << 1) | (p >> (n - 1))) & (ALL_SET >> (POLY_BITS - n));
  endfunction

  // Both cyclic sums, one h coefficient at a time against rotating basis copies.
  function automatic void form_product(input int nw, output poly_words_t t0,
                                       output poly_words_t t1);
    poly_t rf, rg, rbf, rbg, a0, a1, acc0, acc1, msk;
    int    n, j;
    n    = nw * gcm_pkg::WORD_W;
    msk  = ALL_SET >> (POLY_BITS - n);
    rf   = f_word & msk;
    rg   = g_word & msk;
    rbf  = bigf_word & msk;
    rbg  = bigg_word & msk;
    a0   = h0_word & msk;
    a1   = h1_word & msk;
    acc0 = '0;
    acc1 = '0;
    for (j = 0; j < n; j++) begin
      if (a0[j]) begin
        acc0 ^= rf;
        acc1 ^= rg;
      end
      if (a1[j]) begin
        acc0 ^= rbf;
        acc1 ^= rbg;
      end
      rf  = turn_once(rf, n);
      rg  = turn_once(rg, n);
      rbf = turn_once(rbf, n);
      rbg = turn_once(rbg, n);
    end
    t0 = acc0;
    t1 = acc1;
  endfunction

  function automatic void apply_setting(input int index, input setting_t v);
    if (index == REG_LOG_WORDS) begin
      log_setting = v;
      load_ptr    = 0;
      h_ptr       = 0;
    end
  endfunction

  // Update the state for one accepted request and queue the words it produces.
  task automatic absorb(input row_t r);
    int          nw, i, k;
    poly_words_t p0, p1;
    result_t     res;
    nw = words_now();
    if (r.func == OP_BASIS) begin
      i = load_ptr & (nw - 1);
      f_word[i]    = r.f;
      g_word[i]    = r.g;
      bigf_word[i] = r.bf;
      bigg_word[i] = r.bg;
      loaded[i]    = 1'b1;
      load_ptr     = (i + 1) & (nw - 1);
    end else begin
      i = h_ptr & (nw - 1);
      h0_word[i] = r.h0;
      h1_word[i] = r.h1;
      if (i != nw - 1) begin
        h_ptr = i + 1;
      end else begin
        h_ptr = 0;
        products++;
        form_product(nw, p0, p1);
        if (r.typed) begin
          res.t0   = r.want_t0;
          res.t1   = r.want_t1;
          res.last = 1'b1;
          pending_words.push_back(res);
        end else begin
          for (k = 0; k < nw; k++) begin
            res.t0   = p0[k];
            res.t1   = p1[k];
            res.last = (k == nw - 1);
            pending_words.push_back(res);
          end
        end
      end
    end
  endtask

  function automatic row_t req_row(input op_e func, input word_t f, input word_t g,
                                   input word_t bf, input word_t bg, input word_t h0,
                                   input word_t h1, input bit typed, input word_t w0,
                                   input word_t w1);
    row_t r;
    r.kind    = ROW_REQ;
    r.setting = '0;
    r.func    = func;
    r.f       = f;
    r.g       = g;
    r.bf      = bf;
    r.bg      = bg;
    r.h0      = h0;
    r.h1      = h1;
    r.typed   = typed;
    r.want_t0 = w0;
    r.want_t1 = w1;
    return r;
  endfunction

  function automatic row_t cfg_row(input setting_t v);
    row_t r;
    r         = req_row(OP_BASIS, '0, '0, '0, '0, '0, '0, 1'b0, '0, '0);
    r.kind    = ROW_CFG;
    r.setting = v;
    return r;
  endfunction

  function automatic word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  // Every data field is random, including the ones the operation ignores.
  function automatic row_t rand_row(input op_e func);
    return req_row(func, rand_word(), rand_word(), rand_word(), rand_word(),
                   rand_word(), rand_word(), 1'b0, '0, '0);
  endfunction

  // Offer one request after a random gap and wait for it to be taken.
  task automatic send_row(input row_t r);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= r.func;
    in_ch.f_bits    <= r.f;
    in_ch.g_bits    <= r.g;
    in_ch.bigf_bits <= r.bf;
    in_ch.bigg_bits <= r.bg;
    in_ch.h0_bits   <= r.h0;
    in_ch.h1_bits   <= r.h1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    absorb(r);
    items_sent++;
  endtask

  // Stop offering and let every outstanding result arrive.
  task automatic drain_inputs();
    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_log_words(input setting_t v);
    drain_inputs();
    cfg_ch.valid     <= 1'b1;
    cfg_ch.log_words <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    apply_setting(REG_LOG_WORDS, v);
    cfg_writes++;
  endtask

  task automatic note_mismatch(input string field, input word_t want_v, input word_t got_v);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("mismatch on %s at result %0d: expected %h, got %h",
               field, results_seen, want_v, got_v);
  endtask

  // Result checker: every accepted word against the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_words.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("result %0d arrived with nothing pending: t0 %h t1 %h last %b",
                   results_seen, out_ch.t0_word, out_ch.t1_word, out_ch.last_word);
      end else begin
        want = pending_words.pop_front();
        if (out_ch.t0_word !== want.t0) note_mismatch("t0_word", want.t0, out_ch.t0_word);
        if (out_ch.t1_word !== want.t1) note_mismatch("t1_word", want.t1, out_ch.t1_word);
        if (out_ch.last_word !== want.last)
          note_mismatch("last_word", word_t'(want.last), word_t'(out_ch.last_word));
      end
      results_seen++;
    end
  end

  // Receiver: random back-pressure per result, calm stretches, one long hold.
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_wanted && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        gap = ((results_seen / 24) % 3 == 2) ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // Watchdog on cycles in which no channel moves a request.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("no progress for %0d cycles", QUIET_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // Stimulus.
  initial begin
    int               idx, phase, nw, runs, p, k, stop_at;
    setting_t         setting;

    rst              <= 1'b1;
    in_ch.valid      <= 1'b0;
    in_ch.func       <= OP_BASIS;
    in_ch.f_bits     <= '0;
    in_ch.g_bits     <= '0;
    in_ch.bigf_bits  <= '0;
    in_ch.bigg_bits  <= '0;
    in_ch.h0_bits    <= '0;
    in_ch.h1_bits    <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.log_words <= '0;

    log_setting = gcm_pkg::LOG_RESET;
    f_word      = '0;
    g_word      = '0;
    bigf_word   = '0;
    bigg_word   = '0;
    h0_word     = '0;
    h1_word     = '0;
    loaded      = '0;
    load_ptr    = 0;
    h_ptr       = 0;
    errors      = 0;
    results_seen = 0;
    items_sent  = 0;
    products    = 0;
    cfg_writes  = 0;
    sender_calm = 1'b0;
    hold_wanted = 1'b0;
    hold_done   = 1'b0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Single-word products whose answers are plain: identity, X^63 times X
    // wrapping to 1, an all-ones row against ones, and even sums cancelling.
    plan.push_back(cfg_row(3'd0));
    plan.push_back(req_row(OP_BASIS, 64'd1, 64'd0, 64'd0, 64'd1, ONES, ONES,
                           1'b0, '0, '0));
    plan.push_back(req_row(OP_H, ONES, ONES, ONES, ONES, ONES, 64'd0,
                           1'b1, ONES, 64'd0));
    plan.push_back(req_row(OP_H, ONES, ONES, ONES, ONES, 64'd0, TOP_BIT | 64'd1,
                           1'b1, 64'd0, TOP_BIT | 64'd1));
    plan.push_back(req_row(OP_BASIS, 64'd2, ONES, ONES, 64'd0, 64'd0, 64'd0,
                           1'b0, '0, '0));
    plan.push_back(req_row(OP_H, ONES, 64'd0, ONES, 64'd0, TOP_BIT, 64'd0,
                           1'b1, 64'd1, ONES));
    plan.push_back(req_row(OP_BASIS, ONES, ONES, ONES, ONES, 64'd0, 64'd0,
                           1'b0, '0, '0));
    plan.push_back(req_row(OP_H, 64'd0, 64'd0, 64'd0, 64'd0, ONES, ONES,
                           1'b1, 64'd0, 64'd0));
    // Two words: carries across the word boundary, a basis word replaced in
    // the middle of an h sequence, and a register write dropping a partial one.
    plan.push_back(cfg_row(3'd1));
    plan.push_back(req_row(OP_BASIS, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
                           64'h0f0f_0f0f_0f0f_0f0f, 64'ha5a5_a5a5_a5a5_a5a5,
                           64'd0, 64'd0, 1'b0, '0, '0));
    plan.push_back(req_row(OP_BASIS, TOP_BIT, 64'd1, 64'hffff_0000_ffff_0000, 64'd3,
                           ONES, ONES, 1'b0, '0, '0));
    plan.push_back(req_row(OP_H, 64'd0, 64'd0, 64'd0, 64'd0, 64'd1, 64'd0,
                           1'b0, '0, '0));
    plan.push_back(req_row(OP_H, 64'd0, 64'd0, 64'd0, 64'd0, TOP_BIT, ONES,
                           1'b0, '0, '0));
    plan.push_back(req_row(OP_H, ONES, ONES, ONES, ONES, 64'h0000_0001_8000_0000,
                           64'h5555_5555_5555_5555, 1'b0, '0, '0));
    plan.push_back(req_row(OP_BASIS, 64'd0, 64'd0, 64'd0, 64'd0, ONES, ONES,
                           1'b0, '0, '0));
    plan.push_back(req_row(OP_H, 64'd0, 64'd0, 64'd0, 64'd0, ONES, 64'd1,
                           1'b0, '0, '0));
    plan.push_back(req_row(OP_H, 64'd0, 64'd0, 64'd0, 64'd0, ONES, ONES,
                           1'b0, '0, '0));
    plan.push_back(cfg_row(3'd1));
    plan.push_back(req_row(OP_H, 64'd0, 64'd0, 64'd0, 64'd0, 64'h1234_5678_9abc_def0,
                           TOP_BIT, 1'b0, '0, '0));
    plan.push_back(req_row(OP_H, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, ONES,
                           1'b0, '0, '0));

    for (idx = 0; idx < plan.size(); idx++) begin
      if (plan[idx].kind == ROW_CFG)
        write_log_words(plan[idx].setting);
      else
        send_row(plan[idx]);
    end

    // Random phases: a word-count setting, a basis when one is needed, then
    // complete h sequences with stray basis loads and the odd broken tail.
    stop_at = items_sent + RANDOM_ITEMS;
    phase   = 0;
    while (items_sent < stop_at) begin
      case (phase)
        0: setting = 3'd7;
        1: setting = 3'd0;
        2: setting = 3'd1;
        3: setting = 3'd2;
        4: setting = 3'd3;
        5: setting = 3'd5;
        6: setting = 3'd4;
        default: setting = setting_t'(($urandom_range(0, 9) == 0) ? 6 :
                                      $urandom_range(0, 3));
      endcase
      write_log_words(setting);
      nw = words_now();
      sender_calm = (phase % 3 == 1);
      if (phase == 2) hold_wanted = 1'b1;
      if (!basis_ready(nw) || $urandom_range(0, 2) == 0) begin
        for (k = 0; k < nw; k++) send_row(rand_row(OP_BASIS));
      end
      runs = (nw >= 8) ? 1 : $urandom_range(2, 5);
      for (p = 0; p < runs; p++) begin
        for (k = 0; k < nw; k++) begin
          if ($urandom_range(0, 7) == 0) send_row(rand_row(OP_BASIS));
          send_row(rand_row(OP_H));
        end
        // The hold phase keeps offering so that the block backs up.
        if (p == 0 && (phase == 1 || (phase != 2 && $urandom_range(0, 3) == 0)))
          drain_inputs();
      end
      // A partial h sequence is left for the next register write to discard.
      if (nw > 1 && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, nw - 1)) send_row(rand_row(OP_H));
      end
      phase++;
    end

    drain_inputs();
    repeat (TAIL) @(posedge clk);

    $display("%0d requests, %0d products, %0d result words checked, %0d register writes",
             items_sent, products, results_seen, cfg_writes);
    $display("word counts from 1 to 16 with saturated settings; %0d mismatches", errors);
    if (errors == 0 && pending_words.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
